[rtl/indexed_max_heap_defines.svh]
// assertion macros for the indexed max-heap
// used by rtl/indexed_max_heap.sv, expects clk and arst_n in scope
`ifndef INDEXED_MAX_HEAP_DEFINES_SVH
`define INDEXED_MAX_HEAP_DEFINES_SVH

// property checked on every clock edge outside reset
`define IMH_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define IMH_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/imh_pkg.sv]
// shared types and constants for the indexed max-heap
// no dependencies
`timescale 1ns / 1ps

package imh_pkg;

	localparam int ID_W     = 8;
	localparam int ID_COUNT = 256;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_EXTRACT = 2'd1,
		CMD_PEEK    = 2'd2,
		CMD_LOOKUP  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_LOOK,
		ST_UPD,
		ST_LAST,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_RD,
		ST_DN_L,
		ST_DN_R,
		ST_FIN
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [ID_W-1:0]    key_id;
		logic signed [31:0] new_priority;
	} req_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    out_id;
		logic signed [31:0] out_priority;
		logic               present;
		logic [7:0]         slot;
		logic               status;
		logic [8:0]         entry_total;
	} rsp_item_t;

endpackage

[rtl/imh_store.sv]
// heap slot memory, id-to-slot position memory and per-id valid bits
// depends on imh_pkg
`timescale 1ns / 1ps

module imh_store #(
	parameter int CAPACITY   = 256,
	parameter int PRIO_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [$clog2(CAPACITY)-1:0]        h_rd_addr,
	output logic [imh_pkg::ID_W-1:0]           h_rd_id,
	output logic signed [PRIO_WIDTH-1:0]       h_rd_prio,
	input  logic                               h_we,
	input  logic [$clog2(CAPACITY)-1:0]        h_wr_addr,
	input  logic [imh_pkg::ID_W-1:0]           h_wr_id,
	input  logic signed [PRIO_WIDTH-1:0]       h_wr_prio,
	input  logic [imh_pkg::ID_W-1:0]           p_rd_addr,
	output logic [$clog2(CAPACITY)-1:0]        p_rd_slot,
	output logic                               p_rd_valid,
	input  logic                               p_we,
	input  logic [imh_pkg::ID_W-1:0]           p_wr_addr,
	input  logic [$clog2(CAPACITY)-1:0]        p_wr_slot,
	input  logic                               v_we,
	input  logic [imh_pkg::ID_W-1:0]           v_id,
	input  logic                               v_val
);
	import imh_pkg::*;

	localparam int SW = $clog2(CAPACITY);

	logic [ID_W+PRIO_WIDTH-1:0] heap_mem [CAPACITY];
	logic [SW-1:0]              pos_mem  [ID_COUNT];
	logic [ID_COUNT-1:0]        valid_q;
	logic [ID_W+PRIO_WIDTH-1:0] h_rd_q;

	always_ff @(posedge clk) begin
		if (h_we) begin
			heap_mem[h_wr_addr] <= {h_wr_id, h_wr_prio};
		end
		h_rd_q <= heap_mem[h_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			pos_mem[p_wr_addr] <= p_wr_slot;
		end
		p_rd_slot <= pos_mem[p_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			p_rd_valid <= 1'b0;
		end else begin
			if (v_we) begin
				valid_q[v_id] <= v_val;
			end
			p_rd_valid <= valid_q[p_rd_addr];
		end
	end

	assign h_rd_id   = h_rd_q[ID_W+PRIO_WIDTH-1:PRIO_WIDTH];
	assign h_rd_prio = h_rd_q[PRIO_WIDTH-1:0];

endmodule

[rtl/indexed_max_heap.sv]
// indexed binary max-heap: top level with command sequencer and result register
// depends on imh_pkg, imh_store and indexed_max_heap_defines.svh
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req (cmd, key_id, new_priority)
// result  | rsp_valid | rsp_stall | rsp (id, priority, present, slot, status, count)
// one command at a time
// insert sifts up, reading then comparing the parent at each level; extract and
// lowered update sift down, reading left then right child at each level; the single
// read port of the slot memory sets the pace of each level
// reset empties the heap at once through the per-id valid bits, no clearing pass
// a new item is taken while the last result still waits; a finished item waits
// for the result register to free up
`timescale 1ns / 1ps

module indexed_max_heap #(
	parameter int CAPACITY   = 256,
	parameter int PRIO_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  imh_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output imh_pkg::rsp_item_t rsp
);
	import imh_pkg::*;

	`include "indexed_max_heap_defines.svh"

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = SW + 2;

	// sequencer state
	state_t state_q, state_d;
	cmd_t   cmd_q, cmd_d;
	logic [ID_W-1:0] key_q, key_d;
	logic signed [PRIO_WIDTH-1:0] nprio_q, nprio_d;
	logic [CW-1:0] cnt_q, cnt_d;

	// the entry being sifted lives here, only written at its final slot
	logic [ID_W-1:0] cur_id_q, cur_id_d;
	logic signed [PRIO_WIDTH-1:0] cur_prio_q, cur_prio_d;
	logic [SW-1:0] i_q, i_d;

	// left child held while the right one is read
	logic [ID_W-1:0] lch_id_q, lch_id_d;
	logic signed [PRIO_WIDTH-1:0] lch_prio_q, lch_prio_d;
	logic has_r_q, has_r_d;

	// result fields built up during the command
	logic [ID_W-1:0] r_id_q, r_id_d;
	logic signed [PRIO_WIDTH-1:0] r_prio_q, r_prio_d;
	logic r_pres_q, r_pres_d;
	logic [SW-1:0] r_slot_q, r_slot_d;
	logic r_stat_q, r_stat_d;

	logic      rsp_valid_q, rsp_valid_d;
	rsp_item_t rsp_q, rsp_d;

	// memory ports
	logic [SW-1:0] h_rd_addr;
	logic [ID_W-1:0] h_rd_id;
	logic signed [PRIO_WIDTH-1:0] h_rd_prio;
	logic h_we;
	logic [SW-1:0] h_wr_addr;
	logic [ID_W-1:0] h_wr_id;
	logic signed [PRIO_WIDTH-1:0] h_wr_prio;
	logic [ID_W-1:0] p_rd_addr;
	logic [SW-1:0] p_rd_slot;
	logic p_rd_valid;
	logic p_we;
	logic [ID_W-1:0] p_wr_addr;
	logic [SW-1:0] p_wr_slot;
	logic v_we;
	logic [ID_W-1:0] v_id;
	logic v_val;

	// tree arithmetic on the current slot
	logic [XW-1:0] l_x, r_x, cnt_x;
	logic [SW-1:0] parent;
	logic signed [PRIO_WIDTH-1:0] best_prio;
	logic big_l, big_r;

	logic req_acc;

	imh_store #(
		.CAPACITY  (CAPACITY),
		.PRIO_WIDTH(PRIO_WIDTH)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.h_rd_addr (h_rd_addr),
		.h_rd_id   (h_rd_id),
		.h_rd_prio (h_rd_prio),
		.h_we      (h_we),
		.h_wr_addr (h_wr_addr),
		.h_wr_id   (h_wr_id),
		.h_wr_prio (h_wr_prio),
		.p_rd_addr (p_rd_addr),
		.p_rd_slot (p_rd_slot),
		.p_rd_valid(p_rd_valid),
		.p_we      (p_we),
		.p_wr_addr (p_wr_addr),
		.p_wr_slot (p_wr_slot),
		.v_we      (v_we),
		.v_id      (v_id),
		.v_val     (v_val)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign l_x    = XW'({i_q, 1'b1});
	assign r_x    = l_x + XW'(1);
	assign cnt_x  = XW'(cnt_q);
	assign parent = SW'((i_q - SW'(1)) >> 1);

	// sift-down choice: strict compares, left wins ties with right
	assign big_l     = (lch_prio_q > cur_prio_q);
	assign best_prio = big_l ? lch_prio_q : cur_prio_q;
	assign big_r     = has_r_q && (h_rd_prio > best_prio);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		key_q      <= key_d;
		nprio_q    <= nprio_d;
		cur_id_q   <= cur_id_d;
		cur_prio_q <= cur_prio_d;
		i_q        <= i_d;
		lch_id_q   <= lch_id_d;
		lch_prio_q <= lch_prio_d;
		has_r_q    <= has_r_d;
		r_id_q     <= r_id_d;
		r_prio_q   <= r_prio_d;
		r_pres_q   <= r_pres_d;
		r_slot_q   <= r_slot_d;
		r_stat_q   <= r_stat_d;
		rsp_q      <= rsp_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd_d       = cmd_q;
		key_d       = key_q;
		nprio_d     = nprio_q;
		cnt_d       = cnt_q;
		cur_id_d    = cur_id_q;
		cur_prio_d  = cur_prio_q;
		i_d         = i_q;
		lch_id_d    = lch_id_q;
		lch_prio_d  = lch_prio_q;
		has_r_d     = has_r_q;
		r_id_d      = r_id_q;
		r_prio_d    = r_prio_q;
		r_pres_d    = r_pres_q;
		r_slot_d    = r_slot_q;
		r_stat_d    = r_stat_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;

		h_rd_addr = '0;
		h_we      = 1'b0;
		h_wr_addr = i_q;
		h_wr_id   = cur_id_q;
		h_wr_prio = cur_prio_q;
		p_rd_addr = req.key_id;
		p_we      = 1'b0;
		p_wr_addr = cur_id_q;
		p_wr_slot = i_q;
		v_we      = 1'b0;
		v_id      = key_q;
		v_val     = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				// root and position entry are read speculatively
				if (req_acc) begin
					cmd_d    = req.cmd;
					key_d    = req.key_id;
					nprio_d  = PRIO_WIDTH'(64'(req.new_priority));
					r_id_d   = '0;
					r_prio_d = '0;
					r_pres_d = 1'b0;
					r_slot_d = '0;
					r_stat_d = 1'b0;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				unique case (cmd_q)
					CMD_PEEK: begin
						if (cnt_q == '0) begin
							r_stat_d = 1'b1;
						end else begin
							r_id_d   = h_rd_id;
							r_prio_d = h_rd_prio;
						end
						state_d = ST_FIN;
					end
					CMD_EXTRACT: begin
						if (cnt_q == '0) begin
							r_stat_d = 1'b1;
							state_d  = ST_FIN;
						end else begin
							r_id_d   = h_rd_id;
							r_prio_d = h_rd_prio;
							v_we     = 1'b1;
							v_id     = h_rd_id;
							v_val    = 1'b0;
							cnt_d    = cnt_q - CW'(1);
							if (cnt_q == CW'(1)) begin
								state_d = ST_FIN;
							end else begin
								h_rd_addr = SW'(cnt_q - CW'(1));
								state_d   = ST_LAST;
							end
						end
					end
					CMD_LOOKUP: begin
						r_id_d = key_q;
						if (p_rd_valid) begin
							r_pres_d  = 1'b1;
							r_slot_d  = p_rd_slot;
							h_rd_addr = p_rd_slot;
							state_d   = ST_LOOK;
						end else begin
							state_d = ST_FIN;
						end
					end
					CMD_INSERT: begin
						cur_id_d   = key_q;
						cur_prio_d = nprio_q;
						if (p_rd_valid) begin
							i_d       = p_rd_slot;
							h_rd_addr = p_rd_slot;
							state_d   = ST_UPD;
						end else if (cnt_q < CW'(CAPACITY)) begin
							i_d     = SW'(cnt_q);
							cnt_d   = cnt_q + CW'(1);
							v_we    = 1'b1;
							state_d = ST_UP_RD;
						end else begin
							state_d = ST_FIN;
						end
					end
					default: state_d = ST_FIN;
				endcase
			end
			ST_LOOK: begin
				r_prio_d = h_rd_prio;
				state_d  = ST_FIN;
			end
			ST_UPD: begin
				priority if (nprio_q > h_rd_prio) begin
					state_d = ST_UP_RD;
				end else if (h_rd_prio > nprio_q) begin
					state_d = ST_DN_RD;
				end else begin
					h_we    = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_LAST: begin
				// last entry moves to the root and sinks from there
				cur_id_d   = h_rd_id;
				cur_prio_d = h_rd_prio;
				i_d        = '0;
				state_d    = ST_DN_RD;
			end
			ST_UP_RD: begin
				if (i_q == '0) begin
					h_we    = 1'b1;
					p_we    = 1'b1;
					state_d = ST_FIN;
				end else begin
					h_rd_addr = parent;
					state_d   = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				if (cur_prio_q > h_rd_prio) begin
					// parent moves down into the hole
					h_we      = 1'b1;
					h_wr_id   = h_rd_id;
					h_wr_prio = h_rd_prio;
					p_we      = 1'b1;
					p_wr_addr = h_rd_id;
					i_d       = parent;
					state_d   = ST_UP_RD;
				end else begin
					h_we    = 1'b1;
					p_we    = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_DN_RD: begin
				if (l_x >= cnt_x) begin
					h_we    = 1'b1;
					p_we    = 1'b1;
					state_d = ST_FIN;
				end else begin
					h_rd_addr = l_x[SW-1:0];
					state_d   = ST_DN_L;
				end
			end
			ST_DN_L: begin
				lch_id_d   = h_rd_id;
				lch_prio_d = h_rd_prio;
				has_r_d    = (r_x < cnt_x);
				h_rd_addr  = r_x[SW-1:0];
				state_d    = ST_DN_R;
			end
			ST_DN_R: begin
				priority if (big_r) begin
					h_we      = 1'b1;
					h_wr_id   = h_rd_id;
					h_wr_prio = h_rd_prio;
					p_we      = 1'b1;
					p_wr_addr = h_rd_id;
					i_d       = r_x[SW-1:0];
					state_d   = ST_DN_RD;
				end else if (big_l) begin
					h_we      = 1'b1;
					h_wr_id   = lch_id_q;
					h_wr_prio = lch_prio_q;
					p_we      = 1'b1;
					p_wr_addr = lch_id_q;
					i_d       = l_x[SW-1:0];
					state_d   = ST_DN_RD;
				end else begin
					h_we    = 1'b1;
					p_we    = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// wait for the result register to be free
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_d.out_id       = r_id_q;
					rsp_d.out_priority = 32'(64'(r_prio_q));
					rsp_d.present      = r_pres_q;
					rsp_d.slot         = 8'(r_slot_q);
					rsp_d.status       = r_stat_q;
					rsp_d.entry_total  = 9'(cnt_q);
					rsp_valid_d        = 1'b1;
					state_d            = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`IMH_ASSERT(a_cnt_bound, cnt_q <= CW'(CAPACITY), "entry count above capacity")
	`IMH_ASSERT(a_up_order, (state_q == ST_UP_CMP) |-> ($past(state_q) == ST_UP_RD), "sift-up compare without parent read")
	`IMH_ASSERT(a_empty_flag, (rsp_valid && rsp.status) |-> (rsp.entry_total == 9'd0), "empty flag with entries left")
	`IMH_ASSERT(a_rsp_src, $rose(rsp_valid) |-> ($past(state_q) == ST_FIN), "result appeared outside finish")
	`IMH_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> (!rsp_valid || !arst_n), "result valid straight out of reset")

endmodule
